// ===== design/csoc_pkg.sv =====
`default_nettype none
package csoc_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_RANGES  = 64;
   localparam int IDX_W       = $clog2(MAX_RANGES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int COL_W       = 10;
   localparam int VW_W        = 11;
   localparam int ENT_W       = 12;
   localparam int CMP_W       = 13;

   localparam logic signed [ENT_W-1:0] NEG_INF = -12'sd2048;
   localparam logic signed [ENT_W-1:0] POS_INF = 12'sd2047;
   localparam logic [VW_W-1:0] VW_RESET = 11'd320;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SOLID = 2'd1,
      OP_PASS  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_BEFORE,
      PH_MERGE,
      PH_AFTER
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_SCAN,
      KIND_NONE
   } kind_type;

   typedef enum logic [3:0] {
      ST_INIT0,
      ST_INIT1,
      ST_IDLE,
      ST_CLR0,
      ST_CLR1,
      ST_FIRST,
      ST_PROC,
      ST_WR2,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic clr0;
      logic clr1;
      logic start;
      logic step;
      logic wr2;
      logic fin;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     step_ok;
      logic     two;
      logic     last;
      logic     out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== design/csoc_ctrl.sv =====
`default_nettype none
module csoc_ctrl
   import csoc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type st,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_INIT0: begin
            cmd.clr0 = 1'b1;
            state_in = ST_INIT1;
         end
         ST_INIT1: begin
            cmd.clr1 = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (st.kind)
                  KIND_CLEAR: state_in = ST_CLR0;
                  KIND_SCAN:  state_in = ST_FIRST;
                  default:    state_in = ST_FIN;
               endcase
            end
         end
         ST_CLR0: begin
            cmd.clr0 = 1'b1;
            state_in = ST_CLR1;
         end
         ST_CLR1: begin
            cmd.clr1 = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIRST: begin
            cmd.start = 1'b1;
            state_in  = ST_PROC;
         end
         ST_PROC: begin
            if (st.step_ok) begin
               cmd.step = 1'b1;
               if (st.two) begin
                  state_in = ST_WR2;
               end else if (st.last) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_WR2: begin
            cmd.wr2  = 1'b1;
            state_in = st.last ? ST_FIN : ST_PROC;
         end
         ST_FIN: begin
            if (st.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== design/csoc_datapath.sv =====
`default_nettype none
module csoc_datapath
   import csoc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output status_type            st,
   input  wire logic [1:0]       req_op,
   input  wire logic [COL_W-1:0] req_span_first,
   input  wire logic [COL_W-1:0] req_span_last,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [VW_W-1:0]  csr_view_width,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [COL_W-1:0]      rsp_frag_first,
   output logic [COL_W-1:0]      rsp_frag_last,
   output logic                  rsp_visible,
   output logic                  rsp_overflow,
   output logic                  rsp_final_res
);

   logic [VW_W-1:0]  vw_ff;
   op_type           op_ff;
   logic [COL_W-1:0] f_ff, l_ff;
   logic             commit_ff;
   logic             bank_ff;
   logic [CNT_W-1:0] cnt_ff, idx_ff, widx_ff;
   phase_type        phase_ff;
   logic signed [ENT_W-1:0] mlo_ff, mhi_ff;
   logic             ovf_ff;
   logic             pend_v_ff;
   logic [COL_W-1:0] pend_first_ff, pend_last_ff;

   logic [2*ENT_W-1:0] mem [2*MAX_RANGES];
   logic [2*ENT_W-1:0] rd_ff;

   logic             rsp_valid_ff, rsp_visible_ff, rsp_overflow_ff, rsp_final_ff;
   logic [COL_W-1:0] rsp_first_ff, rsp_last_ff;

   // step decode
   logic signed [CMP_W-1:0] rl, rh, ff, ll, ml, mh, e_a, e_b, cand_lo;
   logic              emit_raw, emit, wr, two, ovf_now, solid, out_free, wr_ok;
   logic signed [CMP_W-1:0] w_lo, w_hi;
   phase_type         phase_in;
   logic signed [CMP_W-1:0] mlo_in, mhi_in;
   logic [VW_W-1:0]   vw_clamp;
   op_type            req_op_t;

   logic                 we, rd_en;
   logic [IDX_W:0]       waddr;
   logic [2*ENT_W-1:0]   wdata;
   logic [CNT_W-1:0]     idx_in;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign solid     = (op_ff == OP_SOLID);
   assign req_op_t  = op_type'(req_op);
   assign vw_clamp  = (vw_ff > VW_W'(MAX_COLUMNS)) ? VW_W'(MAX_COLUMNS) : vw_ff;

   assign rl = {rd_ff[2*ENT_W-1], rd_ff[2*ENT_W-1:ENT_W]};
   assign rh = {rd_ff[ENT_W-1], rd_ff[ENT_W-1:0]};
   assign ff = {3'b000, f_ff};
   assign ll = {3'b000, l_ff};
   assign ml = {mlo_ff[ENT_W-1], mlo_ff};
   assign mh = {mhi_ff[ENT_W-1], mhi_ff};

   always_comb begin
      emit_raw = 1'b0;
      e_a      = '0;
      e_b      = '0;
      wr       = 1'b0;
      w_lo     = rl;
      w_hi     = rh;
      two      = 1'b0;
      ovf_now  = 1'b0;
      phase_in = phase_ff;
      mlo_in   = ml;
      mhi_in   = mh;
      cand_lo  = rl;
      unique case (phase_ff)
         PH_BEFORE: begin
            if (rh < ff - 13'sd1) begin
               wr = 1'b1;
            end else if (ff < rl && ll < rl - 13'sd1) begin
               // range lies wholly in the gap before this entry
               emit_raw = 1'b1;
               e_a      = ff;
               e_b      = ll;
               wr       = 1'b1;
               w_lo     = ff;
               w_hi     = ll;
               two      = 1'b1;
               ovf_now  = solid && (cnt_ff == CNT_W'(MAX_RANGES));
               phase_in = PH_AFTER;
            end else begin
               if (ff < rl) begin
                  emit_raw = 1'b1;
                  e_a      = ff;
                  e_b      = rl - 13'sd1;
                  cand_lo  = ff;
               end
               if (ll <= rh) begin
                  wr       = 1'b1;
                  w_lo     = cand_lo;
                  phase_in = PH_AFTER;
               end else begin
                  mlo_in   = cand_lo;
                  mhi_in   = rh;
                  phase_in = PH_MERGE;
               end
            end
         end
         PH_MERGE: begin
            if (ll >= rl - 13'sd1) begin
               emit_raw = 1'b1;
               e_a      = mh + 13'sd1;
               e_b      = rl - 13'sd1;
               if (ll <= rh) begin
                  wr       = 1'b1;
                  w_lo     = ml;
                  phase_in = PH_AFTER;
               end else begin
                  mhi_in = rh;
               end
            end else begin
               emit_raw = 1'b1;
               e_a      = mh + 13'sd1;
               e_b      = ll;
               wr       = 1'b1;
               w_lo     = ml;
               w_hi     = ll;
               two      = 1'b1;
               phase_in = PH_AFTER;
            end
         end
         default: wr = 1'b1;
      endcase
   end

   assign emit  = emit_raw && (e_a <= e_b);
   assign wr_ok = solid && !ovf_ff && !ovf_now;

   always_comb begin
      st.kind = KIND_NONE;
      if (req_op_t == OP_CLEAR) begin
         st.kind = KIND_CLEAR;
      end else if ((req_op_t == OP_SOLID || req_op_t == OP_PASS)
                   && req_span_first <= req_span_last) begin
         st.kind = KIND_SCAN;
      end
      st.step_ok  = !emit || !pend_v_ff || out_free;
      st.two      = two;
      st.last     = (idx_ff + CNT_W'(1)) >= cnt_ff;
      st.out_free = out_free;
   end

   // list memory, two banks: scan reads one and rebuilds into the other
   always_comb begin
      we    = 1'b0;
      waddr = {~bank_ff, widx_ff[IDX_W-1:0]};
      wdata = {w_lo[ENT_W-1:0], w_hi[ENT_W-1:0]};
      if (cmd.clr0) begin
         we    = 1'b1;
         waddr = {bank_ff, IDX_W'(0)};
         wdata = {NEG_INF, -12'sd1};
      end else if (cmd.clr1) begin
         we    = 1'b1;
         waddr = {bank_ff, IDX_W'(1)};
         wdata = {1'b0, vw_clamp, POS_INF};
      end else if (cmd.step) begin
         we = wr && wr_ok;
      end else if (cmd.wr2) begin
         we    = wr_ok;
         wdata = rd_ff;
      end
      rd_en  = cmd.start || (cmd.step && !two) || cmd.wr2;
      idx_in = cmd.start ? '0 : idx_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_ff <= mem[{bank_ff, idx_in[IDX_W-1:0]}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vw_ff        <= VW_RESET;
         bank_ff      <= 1'b0;
         cnt_ff       <= CNT_W'(2);
         pend_v_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_BEFORE;
      end else begin
         if (csr_valid) begin
            vw_ff <= csr_view_width;
         end
         if (cmd.load) begin
            op_ff     <= req_op_t;
            f_ff      <= req_span_first;
            l_ff      <= req_span_last;
            commit_ff <= (req_op_t == OP_SOLID) && (req_span_first <= req_span_last);
            ovf_ff    <= 1'b0;
            pend_v_ff <= 1'b0;
         end
         if (cmd.clr1) begin
            cnt_ff <= CNT_W'(2);
         end
         if (cmd.start) begin
            widx_ff  <= '0;
            phase_ff <= PH_BEFORE;
         end
         if (rd_en) begin
            idx_ff <= idx_in;
         end
         if (cmd.step) begin
            phase_ff <= phase_in;
            mlo_ff   <= mlo_in[ENT_W-1:0];
            mhi_ff   <= mhi_in[ENT_W-1:0];
            ovf_ff   <= ovf_ff | ovf_now;
            if (wr) begin
               widx_ff <= widx_ff + CNT_W'(1);
            end
            if (emit) begin
               pend_v_ff     <= 1'b1;
               pend_first_ff <= e_a[COL_W-1:0];
               pend_last_ff  <= e_b[COL_W-1:0];
            end
         end
         if (cmd.wr2) begin
            widx_ff <= widx_ff + CNT_W'(1);
         end
         if (cmd.fin && commit_ff && !ovf_ff) begin
            bank_ff <= ~bank_ff;
            cnt_ff  <= widx_ff;
         end

         // result register: a pending fragment goes out on the next emit or at fin
         if (cmd.fin) begin
            rsp_valid_ff    <= 1'b1;
            rsp_first_ff    <= pend_v_ff ? pend_first_ff : '0;
            rsp_last_ff     <= pend_v_ff ? pend_last_ff : '0;
            rsp_visible_ff  <= pend_v_ff;
            rsp_overflow_ff <= ovf_ff;
            rsp_final_ff    <= 1'b1;
         end else if (cmd.step && emit && pend_v_ff) begin
            rsp_valid_ff    <= 1'b1;
            rsp_first_ff    <= pend_first_ff;
            rsp_last_ff     <= pend_last_ff;
            rsp_visible_ff  <= 1'b1;
            rsp_overflow_ff <= 1'b0;
            rsp_final_ff    <= 1'b0;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frag_first = rsp_first_ff;
   assign rsp_frag_last  = rsp_last_ff;
   assign rsp_visible    = rsp_visible_ff;
   assign rsp_overflow   = rsp_overflow_ff;
   assign rsp_final_res  = rsp_final_ff;

endmodule
`default_nettype wire

// ===== design/column_span_occlusion_clipper_unit.sv =====
`default_nettype none
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  req_op, req_span_first, req_span_last
// rsp       out  rsp_valid/rsp_stall  rsp_frag_first/last, visible, overflow, final_res
// csr       in   csr_valid/csr_ready  csr_view_width
//
// a scan item visits every list entry in turn, since each entry is
// read once from the list memory; an insert before an entry adds the ST_WR2 state
// clear items pass ST_CLR0 and ST_CLR1; op code 3 and inverted spans go to ST_FIN
// after reset ST_INIT0 and ST_INIT1 write the two sentinels while req_stall stays high
// a stalled rsp beat holds the scan whenever the next fragment needs the output register
module column_span_occlusion_clipper_unit
   import csoc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_op,
   input  wire logic [COL_W-1:0] req_span_first,
   input  wire logic [COL_W-1:0] req_span_last,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [COL_W-1:0]      rsp_frag_first,
   output logic [COL_W-1:0]      rsp_frag_last,
   output logic                  rsp_visible,
   output logic                  rsp_overflow,
   output logic                  rsp_final_res,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [VW_W-1:0]  csr_view_width
);

   cmd_type    cmd;
   status_type st;

   csoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   csoc_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_op         (req_op),
      .req_span_first (req_span_first),
      .req_span_last  (req_span_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_view_width (csr_view_width),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frag_first (rsp_frag_first),
      .rsp_frag_last  (rsp_frag_last),
      .rsp_visible    (rsp_visible),
      .rsp_overflow   (rsp_overflow),
      .rsp_final_res  (rsp_final_res)
   );

endmodule
`default_nettype wire

// ===== tb/sv/column_span_occlusion_clipper_unit_chk.sv =====
module column_span_occlusion_clipper_unit_chk
   import csoc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire logic [1:0]       req_op,
   input  wire logic [COL_W-1:0] req_span_first,
   input  wire logic [COL_W-1:0] req_span_last,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire logic [COL_W-1:0] rsp_frag_first,
   input  wire logic [COL_W-1:0] rsp_frag_last,
   input  wire logic             rsp_visible,
   input  wire logic             rsp_overflow,
   input  wire logic             rsp_final_res,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [VW_W-1:0]  csr_view_width,
   output int                    errors,
   output int                    pending,
   output int                    frag_beats,
   output int                    ovf_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint LO_SENT = -64'sh7fffffff;
   localparam longint HI_SENT = 64'sh7fffffff;

   typedef struct {
      logic [COL_W-1:0] first;
      logic [COL_W-1:0] last;
      logic             vis;
      logic             ovf;
      logic             fin;
   } frag_type;

   frag_type          frag_q[$];
   longint            occ_lo[MAX_RANGES];
   longint            occ_hi[MAX_RANGES];
   int                occ_cnt;
   logic [VW_W-1:0]   width_reg;
   int                made;

   function automatic void reset_list();
      longint w;
      w = (width_reg > MAX_COLUMNS) ? MAX_COLUMNS : width_reg;
      for (int i = 0; i < MAX_RANGES; i++) begin
         occ_lo[i] = 0;
         occ_hi[i] = 0;
      end
      occ_lo[0] = LO_SENT;
      occ_hi[0] = -1;
      occ_lo[1] = w;
      occ_hi[1] = HI_SENT;
      occ_cnt = 2;
   endfunction

   function automatic void add_frag(longint a, longint b);
      frag_type e;
      if (a > b || made >= MAX_RANGES) return;
      e.first = a[COL_W-1:0];
      e.last = b[COL_W-1:0];
      e.vis = 1'b1;
      e.ovf = 1'b0;
      e.fin = 1'b0;
      frag_q.push_back(e);
      made++;
   endfunction

   function automatic bit clip_span(longint f, longint l, bit solid);
      int  s;
      int  n;
      int  gone;
      bit  joined;
      s = 0;
      while (s + 1 < occ_cnt && occ_hi[s] < f - 1) s++;
      if (f < occ_lo[s]) begin
         if (l < occ_lo[s] - 1) begin
            add_frag(f, l);
            if (!solid) return 0;
            if (occ_cnt >= MAX_RANGES) return 1;
            for (int i = occ_cnt; i > s; i--) begin
               occ_lo[i] = occ_lo[i-1];
               occ_hi[i] = occ_hi[i-1];
            end
            occ_lo[s] = f;
            occ_hi[s] = l;
            occ_cnt++;
            return 0;
         end
         add_frag(f, occ_lo[s] - 1);
         if (solid) occ_lo[s] = f;
      end
      if (l <= occ_hi[s]) return 0;
      n = s;
      joined = 0;
      while (!joined && n + 1 < occ_cnt && l >= occ_lo[n+1] - 1) begin
         add_frag(occ_hi[n] + 1, occ_lo[n+1] - 1);
         n++;
         if (l <= occ_hi[n]) begin
            if (solid) occ_hi[s] = occ_hi[n];
            joined = 1;
         end
      end
      if (!joined) begin
         add_frag(occ_hi[n] + 1, l);
         if (solid) occ_hi[s] = l;
      end
      if (!solid || n == s) return 0;
      gone = n - s;
      for (int i = n + 1; i < occ_cnt; i++) begin
         occ_lo[i-gone] = occ_lo[i];
         occ_hi[i-gone] = occ_hi[i];
      end
      occ_cnt -= gone;
      return 0;
   endfunction

   function automatic void predict_item(logic [1:0] op, longint f, longint l);
      bit       ovf;
      frag_type e;
      made = 0;
      ovf = 0;
      if (op == OP_CLEAR) reset_list();
      else if ((op == OP_SOLID || op == OP_PASS) && f <= l)
         ovf = clip_span(f, l, op == OP_SOLID);
      if (made == 0) begin
         e.first = '0;
         e.last = '0;
         e.vis = 1'b0;
         e.ovf = 1'b0;
         e.fin = 1'b0;
         frag_q.push_back(e);
      end
      frag_q[$].ovf = ovf;
      frag_q[$].fin = 1'b1;
   endfunction

   always @(posedge clock) begin
      frag_type w;
      if (reset) begin
         width_reg = VW_RESET;
         reset_list();
         frag_q.delete();
         errors = 0;
         frag_beats = 0;
         ovf_beats = 0;
      end else begin
         if (csr_valid && csr_ready) width_reg = csr_view_width;
         if (req_valid && !req_stall)
            predict_item(req_op, req_span_first, req_span_last);
         if (rsp_valid && !rsp_stall) begin
            if (rsp_visible) frag_beats++;
            if (rsp_overflow) ovf_beats++;
            if (frag_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("%0t: result beat with nothing expected", $realtime);
            end else begin
               w = frag_q.pop_front();
               if (rsp_frag_first !== w.first || rsp_frag_last !== w.last ||
                   rsp_visible !== w.vis || rsp_overflow !== w.ovf ||
                   rsp_final_res !== w.fin) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch exp %0d..%0d v%0b o%0b f%0b got %0d..%0d v%0b o%0b f%0b",
                        $realtime, w.first, w.last, w.vis, w.ovf, w.fin, rsp_frag_first,
                        rsp_frag_last, rsp_visible, rsp_overflow, rsp_final_res);
               end
            end
         end
      end
      pending = frag_q.size();
   end

endmodule

// ===== tb/sv/column_span_occlusion_clipper_unit_tb.sv =====
module column_span_occlusion_clipper_unit_tb;
   import csoc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [1:0]       req_op;
   logic [COL_W-1:0] req_span_first;
   logic [COL_W-1:0] req_span_last;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [COL_W-1:0] rsp_frag_first;
   logic [COL_W-1:0] rsp_frag_last;
   logic             rsp_visible;
   logic             rsp_overflow;
   logic             rsp_final_res;
   logic             csr_valid;
   logic             csr_ready;
   logic [VW_W-1:0]  csr_view_width;
   int               errors;
   int               pending;
   int               frag_beats;
   int               ovf_beats;
   int               items_sent;
   bit               quiet;
   int               col_lim;

   column_span_occlusion_clipper_unit i_dut (.*);
   column_span_occlusion_clipper_unit_chk i_chk (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

   // result side back-pressure in bursts
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = $urandom_range(1, 13);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_item(op_type op, int f, int l);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_op <= op;
      req_span_first <= f[COL_W-1:0];
      req_span_last <= l[COL_W-1:0];
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_width(int w);
      settle();
      csr_view_width <= w[VW_W-1:0];
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      col_lim = (w > MAX_COLUMNS) ? MAX_COLUMNS : ((w < 1) ? 1 : w);
   endtask

   task automatic random_item();
      int r;
      int f;
      int l;
      r = $urandom_range(0, 99);
      f = $urandom_range(0, col_lim - 1);
      l = f + $urandom_range(0, (r % 3 == 0) ? 200 : 30);
      if (l > 1023) l = 1023;
      if (r < 45) send_item(OP_SOLID, f, l);
      else if (r < 78) send_item(OP_PASS, f, l);
      else if (r < 83) send_item(OP_CLEAR, f, l);
      else if (r < 88) send_item(OP_NONE, f, l);
      else if (r < 93) send_item(OP_SOLID, l + 1, f);
      else send_item(op_type'($urandom_range(0, 3)), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
   endtask

   initial begin
      int widths[8];
      widths = '{1, 1024, 0, 2047, 320, 0, 17, 0};
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_CLEAR;
      req_span_first = '0;
      req_span_last = '0;
      csr_valid = 1'b0;
      csr_view_width = '0;
      items_sent = 0;
      quiet = 0;
      col_lim = 320;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset width, edges, every op, inverted span
      send_item(OP_PASS, 0, 1023);
      send_item(OP_SOLID, 0, 0);
      send_item(OP_SOLID, 319, 1023);
      send_item(OP_PASS, 0, 1023);
      send_item(OP_SOLID, 10, 20);
      send_item(OP_SOLID, 22, 30);
      send_item(OP_SOLID, 21, 21);
      send_item(OP_SOLID, 5, 40);
      send_item(OP_PASS, 1023, 1023);
      send_item(OP_SOLID, 50, 40);
      send_item(OP_NONE, 1023, 0);
      send_item(OP_CLEAR, 1023, 1023);
      send_item(OP_PASS, 100, 200);

      // fill the list until it overflows, then a pass with the most fragments
      write_width(1024);
      send_item(OP_CLEAR, 0, 0);
      for (int k = 0; k < 66; k++) send_item(OP_SOLID, 1022 - 4 * k, 1022 - 4 * k);
      send_item(OP_PASS, 0, 1023);
      send_item(OP_SOLID, 0, 1023);
      send_item(OP_PASS, 0, 1023);

      for (int ph = 0; ph < 8; ph++) begin
         write_width((widths[ph] == 0 && ph > 2) ? $urandom_range(1, 2047) : widths[ph]);
         if (ph == 7) quiet = 1;
         // the new width only applies from a clear on; phase 5 sends no clear
         if (ph != 5) send_item(OP_CLEAR, 0, 0);
         for (int k = 0; k < 38; k++) random_item();
      end
      settle();

      $display("%0d items sent, %0d fragment beats, %0d overflow flags",
         items_sent, frag_beats, ovf_beats);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
